>>> sv/crtc_pkg.sv
// Shared types, register indexes and masks for the CRT controller register file.
package crtc_pkg;

    localparam int NumTiming   = 12;
    localparam int IndexWidth  = 5;
    localparam int TimingIdxW  = $clog2(NumTiming);
    localparam int AddrWidth   = 14;
    localparam int DataWidth   = 8;
    localparam int FrameWidth  = 5;

    typedef enum logic [2:0] {
        ACT_WRITE_INDEX = 3'd0,
        ACT_WRITE_DATA  = 3'd1,
        ACT_READ_DATA   = 3'd2,
        ACT_READ_INDEX  = 3'd3,
        ACT_FRAME_TICK  = 3'd4
    } t_action;

    // Register numbers that carry a special meaning.
    localparam logic [IndexWidth-1:0] REG_HORIZ_TOTAL   = 5'd0;
    localparam logic [IndexWidth-1:0] REG_HSYNC_POS     = 5'd2;
    localparam logic [IndexWidth-1:0] REG_SYNC_WIDTH    = 5'd3;
    localparam logic [IndexWidth-1:0] REG_VERT_TOTAL    = 5'd4;
    localparam logic [IndexWidth-1:0] REG_VERT_ADJUST   = 5'd5;
    localparam logic [IndexWidth-1:0] REG_VSYNC_POS     = 5'd7;
    localparam logic [IndexWidth-1:0] REG_INTERLACE     = 5'd8;
    localparam logic [IndexWidth-1:0] REG_MAX_SCANLINE  = 5'd9;
    localparam logic [IndexWidth-1:0] REG_CURSOR_START  = 5'd10;
    localparam logic [IndexWidth-1:0] REG_START_ADDR_HI = 5'd12;
    localparam logic [IndexWidth-1:0] REG_START_ADDR_LO = 5'd13;
    localparam logic [IndexWidth-1:0] REG_CURSOR_HI     = 5'd14;
    localparam logic [IndexWidth-1:0] REG_CURSOR_LO     = 5'd15;

    // Cursor blink modes, taken from cursor-start bits 6:5.
    localparam logic [1:0] BLINK_NONE = 2'd0;
    localparam logic [1:0] BLINK_OFF  = 2'd1;
    localparam logic [1:0] BLINK_SLOW = 2'd2;
    localparam logic [1:0] BLINK_FAST = 2'd3;

    localparam logic [DataWidth-1:0] OffsetMax = 8'd128;

    // Timing register values that feed the vertical offset.
    typedef struct packed {
        logic [DataWidth-1:0] vert_total;
        logic [DataWidth-1:0] vsync_pos;
        logic [DataWidth-1:0] max_scanline;
        logic [DataWidth-1:0] vert_adjust;
    } t_offset_regs;

    function automatic logic [DataWidth-1:0] reg_mask(input logic [TimingIdxW-1:0] idx);
        logic [DataWidth-1:0] m;
        case (idx)
            4'd0, 4'd1, 4'd2: m = 8'hFF;
            4'd3:             m = 8'h0F;
            4'd4:             m = 8'h7F;
            4'd5:             m = 8'h1F;
            4'd6, 4'd7:       m = 8'h7F;
            4'd8:             m = 8'h03;
            4'd9:             m = 8'h1F;
            4'd10:            m = 8'h7F;
            4'd11:            m = 8'h1F;
            default:          m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

>>> sv/crtc_offset.sv
// Vertical display offset: (total - sync) * (scan lines + 1) + adjust - 32, clamped to 0..128.
module crtc_offset (
    input  crtc_pkg::t_offset_regs          i_regs,
    output logic [crtc_pkg::DataWidth-1:0]  o_offset
);

    logic signed [8:0]  diff;
    logic        [6:0]  lines;
    logic signed [15:0] prod;
    logic signed [15:0] sum;

    always_comb begin
        diff  = $signed({1'b0, i_regs.vert_total}) - $signed({1'b0, i_regs.vsync_pos});
        lines = {2'b00, i_regs.max_scanline[4:0]} + 7'd1;
        prod  = 16'(diff) * $signed({9'd0, lines});
        sum   = prod + $signed({8'd0, i_regs.vert_adjust}) - 16'sd32;
        if (sum < 16'sd0) begin
            o_offset = '0;
        end else if (sum > $signed({8'd0, crtc_pkg::OffsetMax})) begin
            o_offset = crtc_pkg::OffsetMax;
        end else begin
            o_offset = sum[7:0];
        end
    end

endmodule

>>> sv/crtc_register_file_core.sv
// Top level of the CRT controller register file: bus transactions in, one status result out.
//
// Usage. Each input transaction carries an action (write index, write data,
// read data, read index, frame tick) and a data byte. Every accepted input
// transaction produces exactly one output transaction holding the read byte,
// the current clamped vertical offset, the cursor visibility and a redraw
// flag that is high when this transaction changed display-relevant state.
//
// Timing. The register state and the result register are
// both updated at the edge that accepts the input, so the result is valid
// in the cycle after acceptance. The whole update, including the small
// offset multiplier, is one combinational pass, so a new transaction can be
// accepted every cycle while the receiver takes each result.
//
// Stalls. The result register acts as the output stage; o_in_ready is high
// whenever it is empty or is being emptied in the same cycle. A stalled
// receiver therefore holds the input side off after one pending result.
//
// Reset. i_rst_n is synchronous and active low. It clears the index, all
// timing registers, both address registers, the offset, the frame counter,
// the cursor state and the output valid flag.
module crtc_register_file_core (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_write_data,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [7:0] o_vertical_offset,
    output logic       o_cursor_on,
    output logic       o_redraw
);

    localparam int NT = crtc_pkg::NumTiming;
    localparam int DW = crtc_pkg::DataWidth;
    localparam int IW = crtc_pkg::IndexWidth;
    localparam int TW = crtc_pkg::TimingIdxW;
    localparam int AW = crtc_pkg::AddrWidth;
    localparam int FW = crtc_pkg::FrameWidth;

    // Architectural state.
    logic [IW-1:0] r_index,       n_index;
    logic [DW-1:0] r_timing [NT];
    logic [DW-1:0] n_timing [NT];
    logic [AW-1:0] r_start_addr,  n_start_addr;
    logic [AW-1:0] r_cursor_pos,  n_cursor_pos;
    logic [DW-1:0] r_vert_offset, n_vert_offset;
    logic [FW-1:0] r_frame,       n_frame;
    logic          r_cursor_shown, n_cursor_shown;

    // Result register.
    logic          r_out_valid;
    logic [DW-1:0] r_read_data,   n_read_data;
    logic          r_redraw,      n_redraw;

    logic                   accept;
    logic                   recalc;
    logic [TW-1:0]          tidx;
    logic [DW-1:0]          masked;
    logic                   cursor_vis;
    crtc_pkg::t_offset_regs offset_regs;
    logic [DW-1:0]          offset_calc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tidx       = r_index[TW-1:0];

    // Offset sees the timing registers as they will be after this write.
    always_comb begin
        offset_regs.vert_total   = n_timing[crtc_pkg::REG_VERT_TOTAL[TW-1:0]];
        offset_regs.vsync_pos    = n_timing[crtc_pkg::REG_VSYNC_POS[TW-1:0]];
        offset_regs.max_scanline = n_timing[crtc_pkg::REG_MAX_SCANLINE[TW-1:0]];
        offset_regs.vert_adjust  = n_timing[crtc_pkg::REG_VERT_ADJUST[TW-1:0]];
    end

    crtc_offset u_offset (
        .i_regs   (offset_regs),
        .o_offset (offset_calc)
    );

    always_comb begin
        n_index        = r_index;
        n_timing       = r_timing;
        n_start_addr   = r_start_addr;
        n_cursor_pos   = r_cursor_pos;
        n_frame        = r_frame;
        n_cursor_shown = r_cursor_shown;
        n_read_data    = '0;
        n_redraw       = 1'b0;
        recalc         = 1'b0;
        masked         = '0;
        cursor_vis     = 1'b0;

        case (crtc_pkg::t_action'(i_action))
            crtc_pkg::ACT_WRITE_INDEX: begin
                n_index = i_write_data[IW-1:0];
            end
            crtc_pkg::ACT_WRITE_DATA: begin
                if (r_index < IW'(NT)) begin
                    masked         = i_write_data & crtc_pkg::reg_mask(tidx);
                    n_timing[tidx] = masked;
                    // Sync width and interlace mode are stored but never redraw.
                    if (r_timing[tidx] != masked
                            && r_index != crtc_pkg::REG_SYNC_WIDTH
                            && r_index != crtc_pkg::REG_INTERLACE) begin
                        n_redraw = 1'b1;
                        recalc   = r_index inside {crtc_pkg::REG_HORIZ_TOTAL,
                                                   crtc_pkg::REG_HSYNC_POS,
                                                   crtc_pkg::REG_VERT_TOTAL,
                                                   crtc_pkg::REG_VERT_ADJUST,
                                                   crtc_pkg::REG_VSYNC_POS,
                                                   crtc_pkg::REG_MAX_SCANLINE};
                    end
                end else begin
                    case (r_index)
                        crtc_pkg::REG_START_ADDR_HI: begin
                            n_start_addr[13:8] = i_write_data[5:0];
                            n_redraw = r_start_addr[13:8] != i_write_data[5:0];
                        end
                        crtc_pkg::REG_START_ADDR_LO: begin
                            n_start_addr[7:0] = i_write_data;
                            n_redraw = r_start_addr[7:0] != i_write_data;
                        end
                        crtc_pkg::REG_CURSOR_HI: begin
                            n_cursor_pos[13:8] = i_write_data[5:0];
                            n_redraw = r_cursor_pos[13:8] != i_write_data[5:0];
                        end
                        crtc_pkg::REG_CURSOR_LO: begin
                            n_cursor_pos[7:0] = i_write_data;
                            n_redraw = r_cursor_pos[7:0] != i_write_data;
                        end
                        default: begin
                            n_redraw = 1'b0;
                        end
                    endcase
                end
            end
            crtc_pkg::ACT_READ_DATA: begin
                if (r_index == crtc_pkg::REG_CURSOR_HI) begin
                    n_read_data = {2'b00, r_cursor_pos[13:8]};
                end else if (r_index == crtc_pkg::REG_CURSOR_LO) begin
                    n_read_data = r_cursor_pos[7:0];
                end
            end
            crtc_pkg::ACT_READ_INDEX: begin
                n_read_data = {{(DW-IW){1'b0}}, r_index};
            end
            crtc_pkg::ACT_FRAME_TICK: begin
                n_frame = r_frame + FW'(1);
                // Visibility is only re-evaluated on even frame counts.
                if (!n_frame[0]) begin
                    case (r_timing[crtc_pkg::REG_CURSOR_START[TW-1:0]][6:5])
                        crtc_pkg::BLINK_NONE: cursor_vis = 1'b1;
                        crtc_pkg::BLINK_OFF:  cursor_vis = 1'b0;
                        crtc_pkg::BLINK_SLOW: cursor_vis = n_frame[4];
                        crtc_pkg::BLINK_FAST: cursor_vis = n_frame[3];
                        default:              cursor_vis = 1'b0;
                    endcase
                    n_cursor_shown = cursor_vis;
                    n_redraw       = cursor_vis != r_cursor_shown;
                end
            end
            default: begin
                n_read_data = '0;
            end
        endcase

        n_vert_offset = recalc ? offset_calc : r_vert_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index        <= '0;
            r_start_addr   <= '0;
            r_cursor_pos   <= '0;
            r_vert_offset  <= '0;
            r_frame        <= '0;
            r_cursor_shown <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                r_timing[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_index        <= n_index;
                r_timing       <= n_timing;
                r_start_addr   <= n_start_addr;
                r_cursor_pos   <= n_cursor_pos;
                r_vert_offset  <= n_vert_offset;
                r_frame        <= n_frame;
                r_cursor_shown <= n_cursor_shown;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_redraw    <= n_redraw;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_read_data;
    assign o_vertical_offset = r_vert_offset;
    assign o_cursor_on       = r_cursor_shown;
    assign o_redraw          = r_redraw;

endmodule

>>> sim/crtc_register_file_core_tb.sv
// Self-checking testbench for the CRT controller register file core.
`timescale 1ns / 1ps

module crtc_register_file_core_tb;

    // Action codes beyond the frame tick do nothing in the block.
    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

    // Register numbers the package leaves unnamed, and the bounds of the index range.
    localparam logic [crtc_pkg::IndexWidth-1:0] REG_HORIZ_DISPLAYED = 5'd1;
    localparam logic [crtc_pkg::IndexWidth-1:0] REG_VERT_DISPLAYED  = 5'd6;
    localparam logic [crtc_pkg::IndexWidth-1:0] REG_CURSOR_END      = 5'd11;
    localparam logic [crtc_pkg::IndexWidth-1:0] REG_LAST_PHYSICAL   = 5'd15;
    localparam logic [crtc_pkg::IndexWidth-1:0] REG_INDEX_TOP       = 5'd31;

    localparam int OFFSET_BIAS    = 32;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data;
        logic       drain;     // hold this transaction until all results are back
    } t_bus_access;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vert_offset;
        logic       cursor_on;
        logic       redraw;
    } t_crtc_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_action = '0;
    logic [7:0] i_write_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_read_data;
    logic [7:0] o_vertical_offset;
    logic       o_cursor_on;
    logic       o_redraw;

    crtc_register_file_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_vertical_offset(o_vertical_offset),
        .o_cursor_on      (o_cursor_on),
        .o_redraw         (o_redraw)
    );

    always #5 i_clk = ~i_clk;

    t_bus_access  pending_accesses[$];
    t_crtc_result expected_results[$];
    t_bus_access  presented;
    int           errors = 0;

    // Shadow copy of the register file state.
    logic [crtc_pkg::IndexWidth-1:0] cur_index;
    logic [7:0]                      timing_shadow [crtc_pkg::NumTiming];
    logic [crtc_pkg::AddrWidth-1:0]  start_addr;
    logic [crtc_pkg::AddrWidth-1:0]  cursor_addr;
    logic [7:0]                      vert_offset;
    logic [crtc_pkg::FrameWidth-1:0] frame_cnt;
    logic                            cursor_vis;

    // Data write into the selected register; returns whether the display changed.
    function automatic logic store_register(input logic [7:0] value);
        logic [7:0] kept;
        logic [7:0] mask;
        logic       changed;
        int         lines;
        changed = 1'b0;
        if (cur_index < crtc_pkg::NumTiming) begin
            case (cur_index)
                crtc_pkg::REG_HORIZ_TOTAL, REG_HORIZ_DISPLAYED, crtc_pkg::REG_HSYNC_POS:
                    mask = 8'hFF;
                crtc_pkg::REG_SYNC_WIDTH:
                    mask = 8'h0F;
                crtc_pkg::REG_VERT_ADJUST, crtc_pkg::REG_MAX_SCANLINE, REG_CURSOR_END:
                    mask = 8'h1F;
                crtc_pkg::REG_INTERLACE:
                    mask = 8'h03;
                default:
                    mask = 8'h7F;
            endcase
            kept = value & mask;
            changed = timing_shadow[cur_index] != kept;
            timing_shadow[cur_index] = kept;
            if (cur_index == crtc_pkg::REG_SYNC_WIDTH
                    || cur_index == crtc_pkg::REG_INTERLACE) begin
                changed = 1'b0;
            end else if (changed && (cur_index == crtc_pkg::REG_HORIZ_TOTAL
                    || cur_index == crtc_pkg::REG_HSYNC_POS
                    || cur_index == crtc_pkg::REG_VERT_TOTAL
                    || cur_index == crtc_pkg::REG_VERT_ADJUST
                    || cur_index == crtc_pkg::REG_VSYNC_POS
                    || cur_index == crtc_pkg::REG_MAX_SCANLINE)) begin
                // Signed offset, clamped into 0..OffsetMax.
                lines = (int'(timing_shadow[crtc_pkg::REG_VERT_TOTAL])
                         - int'(timing_shadow[crtc_pkg::REG_VSYNC_POS]))
                        * (int'(timing_shadow[crtc_pkg::REG_MAX_SCANLINE]) + 1)
                        + int'(timing_shadow[crtc_pkg::REG_VERT_ADJUST]) - OFFSET_BIAS;
                if (lines < 0) begin
                    lines = 0;
                end
                if (lines > int'(crtc_pkg::OffsetMax)) begin
                    lines = int'(crtc_pkg::OffsetMax);
                end
                vert_offset = lines[7:0];
            end
        end else begin
            case (cur_index)
                crtc_pkg::REG_START_ADDR_HI: begin
                    changed = start_addr[13:8] != value[5:0];
                    start_addr[13:8] = value[5:0];
                end
                crtc_pkg::REG_START_ADDR_LO: begin
                    changed = start_addr[7:0] != value;
                    start_addr[7:0] = value;
                end
                crtc_pkg::REG_CURSOR_HI: begin
                    changed = cursor_addr[13:8] != value[5:0];
                    cursor_addr[13:8] = value[5:0];
                end
                crtc_pkg::REG_CURSOR_LO: begin
                    changed = cursor_addr[7:0] != value;
                    cursor_addr[7:0] = value;
                end
                default: changed = 1'b0;
            endcase
        end
        return changed;
    endfunction

    // Applies one bus transaction to the shadow state and gives the result it produces.
    function automatic t_crtc_result apply_bus_access(input t_bus_access acc);
        t_crtc_result res;
        logic         vis;
        res = '0;
        case (acc.action)
            crtc_pkg::ACT_WRITE_INDEX: cur_index = acc.data[crtc_pkg::IndexWidth-1:0];
            crtc_pkg::ACT_WRITE_DATA:  res.redraw = store_register(acc.data);
            crtc_pkg::ACT_READ_DATA: begin
                if (cur_index == crtc_pkg::REG_CURSOR_HI) begin
                    res.read_data = {2'b00, cursor_addr[13:8]};
                end else if (cur_index == crtc_pkg::REG_CURSOR_LO) begin
                    res.read_data = cursor_addr[7:0];
                end
            end
            crtc_pkg::ACT_READ_INDEX:  res.read_data = {3'b000, cur_index};
            crtc_pkg::ACT_FRAME_TICK: begin
                frame_cnt = frame_cnt + 1'b1;
                // Visibility is only reevaluated on even frames.
                if (!frame_cnt[0]) begin
                    case (timing_shadow[crtc_pkg::REG_CURSOR_START][6:5])
                        crtc_pkg::BLINK_NONE: vis = 1'b1;
                        crtc_pkg::BLINK_OFF:  vis = 1'b0;
                        crtc_pkg::BLINK_SLOW: vis = frame_cnt[4];
                        default:              vis = frame_cnt[3];
                    endcase
                    res.redraw = vis != cursor_vis;
                    cursor_vis = vis;
                end
            end
            default: ;
        endcase
        res.vert_offset = vert_offset;
        res.cursor_on   = cursor_vis;
        return res;
    endfunction

    // Idle length: none in quiet stretches, otherwise mostly short with a few long ones.
    function automatic int idle_span(input logic quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) begin
            return 0;
        end
        if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_access(input logic [2:0] action, input logic [7:0] data,
                                input logic drain);
        t_bus_access acc;
        acc.action = action;
        acc.data   = data;
        acc.drain  = drain;
        pending_accesses.push_back(acc);
    endtask

    // Register number for a random sequence: mostly the physical registers.
    function automatic logic [crtc_pkg::IndexWidth-1:0] pick_register();
        if ($urandom_range(0, 9) == 0) begin
            return crtc_pkg::IndexWidth'($urandom_range(REG_LAST_PHYSICAL + 1,
                                                        REG_INDEX_TOP));
        end
        return crtc_pkg::IndexWidth'($urandom_range(0, REG_LAST_PHYSICAL));
    endfunction

    // Data byte: often small so the offset lands inside its range instead of clamping.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 4) begin
            return 8'($urandom_range(0, 7));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    logic tx_quiet = 1'b0;
    int   tx_gap = 0;

    // Sender: presents queued transactions, idling between them at random.
    always @(posedge i_clk) begin : drive_bus
        t_bus_access nxt;
        logic        fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                expected_results.push_back(apply_bus_access(presented));
            end
            if (fire || !i_in_valid) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_accesses.size() > 0
                        && !(pending_accesses[0].drain && expected_results.size() > 0)) begin
                    nxt = pending_accesses.pop_front();
                    presented    <= nxt;
                    i_in_valid   <= 1'b1;
                    i_action     <= nxt.action;
                    i_write_data <= nxt.data;
                    tx_gap       <= idle_span(tx_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                tx_quiet <= !tx_quiet;
            end
        end
    end

    logic rx_quiet = 1'b0;
    int   rx_stall = 0;

    // Receiver: checks every result against the oldest prediction, stalling at random.
    always @(posedge i_clk) begin : check_results
        t_crtc_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result rd=%0d offset=%0d cursor=%0b redraw=%0b",
                             $time, o_read_data, o_vertical_offset, o_cursor_on, o_redraw);
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_data !== want.read_data) begin
                        errors++;
                        $display("%0t: read_data expected %0d actual %0d",
                                 $time, want.read_data, o_read_data);
                    end
                    if (o_vertical_offset !== want.vert_offset) begin
                        errors++;
                        $display("%0t: vertical_offset expected %0d actual %0d",
                                 $time, want.vert_offset, o_vertical_offset);
                    end
                    if (o_cursor_on !== want.cursor_on) begin
                        errors++;
                        $display("%0t: cursor_on expected %0b actual %0b",
                                 $time, want.cursor_on, o_cursor_on);
                    end
                    if (o_redraw !== want.redraw) begin
                        errors++;
                        $display("%0t: redraw expected %0b actual %0b",
                                 $time, want.redraw, o_redraw);
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) begin
                    rx_stall <= idle_span(rx_quiet);
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                rx_quiet <= !rx_quiet;
            end
        end
    end

    int idle_cycles = 0;

    // A stretch with no transaction on either channel means the block hung.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [crtc_pkg::IndexWidth-1:0] idx;
        logic [7:0]                      value;
        int                              kind;
        int                              queued;
        int                              reps;

        cur_index   = '0;
        start_addr  = '0;
        cursor_addr = '0;
        vert_offset = '0;
        frame_cnt   = '0;
        cursor_vis  = 1'b0;
        foreach (timing_shadow[i]) begin
            timing_shadow[i] = '0;
        end

        // Directed part: reads after reset, cursor bytes, offset extremes,
        // unchanged rewrites, out-of-range indexes, ticks and unused actions.
        queue_access(crtc_pkg::ACT_READ_INDEX, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_READ_DATA, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b111, crtc_pkg::REG_CURSOR_HI}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hFF, 1'b0);
        queue_access(crtc_pkg::ACT_READ_DATA, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hC0, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b000, crtc_pkg::REG_CURSOR_LO}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hA5, 1'b0);
        queue_access(crtc_pkg::ACT_READ_DATA, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hA5, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b000, crtc_pkg::REG_VERT_TOTAL}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hFF, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b000, crtc_pkg::REG_MAX_SCANLINE}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hFF, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b000, crtc_pkg::REG_VSYNC_POS}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'h7F, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'b000, crtc_pkg::REG_SYNC_WIDTH}, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'hFF, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_INDEX, 8'hFF, 1'b0);
        queue_access(crtc_pkg::ACT_READ_INDEX, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_WRITE_DATA, 8'h55, 1'b0);
        queue_access(crtc_pkg::ACT_READ_DATA, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_FRAME_TICK, 8'h00, 1'b0);
        queue_access(crtc_pkg::ACT_FRAME_TICK, 8'h00, 1'b0);
        for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++) begin
            queue_access(3'(a), 8'hFF, 1'b0);
        end

        // Random part: mostly index-then-data sequences with random content.
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                idx = pick_register();
                queue_access(crtc_pkg::ACT_WRITE_INDEX, {3'($urandom_range(0, 7)), idx},
                             queued == 0 || $urandom_range(0, 99) == 0);
                queued++;
                reps = $urandom_range(1, 3);
                value = pick_byte();
                for (int r = 0; r < reps; r++) begin
                    // Sometimes rewrite the same byte, which must not redraw.
                    if ($urandom_range(0, 5) != 0) begin
                        value = pick_byte();
                    end
                    queue_access(crtc_pkg::ACT_WRITE_DATA, value, 1'b0);
                    queued++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_access(crtc_pkg::ACT_READ_DATA, 8'($urandom_range(0, 255)), 1'b0);
                    queued++;
                end
            end else if (kind < 72) begin
                reps = $urandom_range(1, 20);
                for (int r = 0; r < reps; r++) begin
                    queue_access(crtc_pkg::ACT_FRAME_TICK, 8'($urandom_range(0, 255)), 1'b0);
                    queued++;
                end
            end else if (kind < 82) begin
                queue_access(crtc_pkg::ACT_WRITE_INDEX,
                             {3'($urandom_range(0, 7)), pick_register()}, 1'b0);
                queue_access(crtc_pkg::ACT_READ_DATA, 8'($urandom_range(0, 255)), 1'b0);
                queue_access(crtc_pkg::ACT_READ_INDEX, 8'($urandom_range(0, 255)), 1'b0);
                queued += 3;
            end else if (kind < 90) begin
                queue_access(3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST)),
                             8'($urandom_range(0, 255)), 1'b0);
                queued++;
            end else begin
                queue_access(3'($urandom_range(0, ACT_RESERVED_LAST)),
                             8'($urandom_range(0, 255)), 1'b0);
                queued++;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/crtc_pkg.sv
sv/crtc_offset.sv
sv/crtc_register_file_core.sv
sim/crtc_register_file_core_tb.sv
